// ===== design/tak_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tak_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned DT_W      = 25;
  localparam int unsigned NOISE_W   = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 31;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSERVE_GAIN  = 3'd4;

  localparam logic [DT_W-1:0]    RST_TIME_STEP     = 25'd83886;
  localparam logic [NOISE_W-1:0] RST_ANGLE_NOISE   = 31'd16777;
  localparam logic [NOISE_W-1:0] RST_BIAS_NOISE    = 31'd83886;
  localparam logic [NOISE_W-1:0] RST_MEASURE_NOISE = 31'd8388608;
  localparam logic [NOISE_W-1:0] RST_OBSERVE_GAIN  = 31'd16777216;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? Q_MIN : Q_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/tak_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tak_mul (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [tak_pkg::DATA_W-1:0] op_a,
  input  wire logic signed [tak_pkg::DATA_W-1:0] op_b,
  output logic signed [tak_pkg::DATA_W-1:0]      q
);
  import tak_pkg::*;

  logic signed [2*DATA_W-1:0]      prod_r;
  logic signed [2*DATA_W-1:0]      rnd;
  logic signed [2*DATA_W-FRAC_W-1:0] shr;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  // Add half an LSB and drop the fraction: round to nearest, ties upward.
  assign rnd = prod_r + (64'sd1 <<< (FRAC_W - 1));
  assign shr = rnd[2*DATA_W-1:FRAC_W];

  always_comb begin
    if (shr > 40'sh00_7FFF_FFFF) begin
      q = Q_MAX;
    end else if (shr < -40'sh00_8000_0000) begin
      q = Q_MIN;
    end else begin
      q = shr[DATA_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/tak_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tak_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [tak_pkg::DATA_W-1:0] num,
  input  wire logic signed [tak_pkg::DATA_W-1:0] den,
  output logic                                   done,
  output logic signed [tak_pkg::DATA_W-1:0]      quo
);
  import tak_pkg::*;

  localparam int unsigned SUM_W = DATA_W + FRAC_W + 1;
  localparam int unsigned CNT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {
    D_IDLE,
    D_ADD,
    D_RUN,
    D_FIN
  } div_state_t;

  div_state_t         state_r;
  logic [DATA_W-1:0]  num_mag_r;
  logic [DATA_W-1:0]  den_mag_r;
  logic               neg_r;
  logic               zero_r;
  logic               ovf_r;
  logic [DATA_W-1:0]  rem_r;
  logic [DATA_W-1:0]  quo_bits_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               done_r;
  logic [DATA_W-1:0]  quo_r;

  logic [SUM_W-1:0]   nsum;
  logic [DATA_W+1:0]  trial;
  logic [DATA_W-1:0]  mag;
  logic [DATA_W-1:0]  res;

  // Dividend is |num| * 2^24 plus half the divisor, so the truncating
  // quotient comes out rounded to nearest.
  assign nsum = {1'b0, num_mag_r, {FRAC_W{1'b0}}} +
                {{(SUM_W-DATA_W){1'b0}}, den_mag_r >> 1};
  assign trial = {1'b0, rem_r, quo_bits_r[DATA_W-1]} - {2'b00, den_mag_r};

  always_comb begin
    if (ovf_r || quo_bits_r > 32'h8000_0000) begin
      mag = 32'h8000_0000;
    end else begin
      mag = quo_bits_r;
    end
    if (zero_r) begin
      res = '0;
    end else if (neg_r) begin
      res = 32'h0 - mag;
    end else if (mag[DATA_W-1]) begin
      res = Q_MAX;
    end else begin
      res = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_FIN);
      case (state_r)
        D_IDLE: begin
          if (start) begin
            num_mag_r <= num[DATA_W-1] ? 32'h0 - num : num;
            den_mag_r <= den[DATA_W-1] ? 32'h0 - den : den;
            neg_r     <= num[DATA_W-1] ^ den[DATA_W-1];
            zero_r    <= (den == '0);
            state_r   <= D_ADD;
          end
        end
        D_ADD: begin
          // A high part at or above the divisor means a quotient of 2^32 or
          // more, which saturates anyway.
          ovf_r      <= ({7'd0, nsum[SUM_W-1:DATA_W]} >= den_mag_r);
          rem_r      <= {7'd0, nsum[SUM_W-1:DATA_W]};
          quo_bits_r <= nsum[DATA_W-1:0];
          cnt_r      <= '0;
          if (zero_r || ({7'd0, nsum[SUM_W-1:DATA_W]} >= den_mag_r)) begin
            state_r <= D_FIN;
          end else begin
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (!trial[DATA_W+1]) begin
            rem_r <= trial[DATA_W-1:0];
          end else begin
            rem_r <= {rem_r[DATA_W-2:0], quo_bits_r[DATA_W-1]};
          end
          quo_bits_r <= {quo_bits_r[DATA_W-2:0], ~trial[DATA_W+1]};
          cnt_r      <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DATA_W - 1)) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          quo_r   <= res;
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== design/tilt_angle_kalman_filter_unit.sv =====
// Flow: after an input transfer, two setup states, fourteen products on one shared
// multiplier (a multiply state and a write-back state each), two divisions on the
// shared bit-serial divider and one output state. A division with a zero divisor or a
// quotient of 2^32 or more skips its 32 steps. No new sample is taken until the last
// is in the output register, which waits for out_tready; in_tready is high only while
// idle. Reset (rst_n, synchronous): state and config registers return to defaults.
`timescale 1ns / 1ps
`default_nettype none
module tilt_angle_kalman_filter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // measured_angle [31:0], gyro_rate [63:32]
  input  wire logic [63:0]                       in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // angle_out [31:0], rate_out [63:32], bias_out [95:64]
  output logic [95:0]                            out_tdata,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tak_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tak_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import tak_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP0,
    S_PREP1,
    S_MUL,
    S_WB,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [3:0] LAST_PREDICT = 4'd7;
  localparam logic [3:0] LAST_STEP    = 4'd13;

  state_t state_r;
  logic [3:0] step_r;
  logic       div_idx_r;
  logic       div_run_r;

  logic [DT_W-1:0]    dt_r;
  logic [NOISE_W-1:0] qa_r;
  logic [NOISE_W-1:0] qg_r;
  logic [NOISE_W-1:0] r_r;
  logic [NOISE_W-1:0] c_r;

  logic signed [DATA_W-1:0] angle_r, bias_r;
  logic signed [DATA_W-1:0] cov00_r, cov01_r, cov10_r, cov11_r;
  logic signed [DATA_W-1:0] meas_r, gyro_r;
  logic signed [DATA_W-1:0] u_r, d0_r, d1_r, err_r;
  logic signed [DATA_W-1:0] pct0_r, pct1_r, e_r, t1_r, k0_r, k1_r;

  logic                     out_tvalid_r;
  logic [95:0]              out_tdata_r;

  logic signed [DATA_W-1:0] dt_s, c_s;
  logic signed [DATA_W-1:0] op_a, op_b, q;
  logic                     mul_en;
  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_quo;
  logic                     out_free;

  assign dt_s = {{(DATA_W-DT_W){1'b0}}, dt_r};
  assign c_s  = {{(DATA_W-NOISE_W){1'b0}}, c_r};

  // Operand selection for each product of the sequence.
  always_comb begin
    case (step_r)
      4'd0:    begin op_a = u_r;                 op_b = dt_s;    end
      4'd1:    begin op_a = d0_r;                op_b = dt_s;    end
      4'd2:    begin op_a = d1_r;                op_b = dt_s;    end
      4'd3:    begin op_a = {1'b0, qg_r};        op_b = dt_s;    end
      4'd4:    begin op_a = c_s;                 op_b = cov00_r; end
      4'd5:    begin op_a = c_s;                 op_b = cov10_r; end
      4'd6:    begin op_a = c_s;                 op_b = pct0_r;  end
      4'd7:    begin op_a = c_s;                 op_b = cov01_r; end
      4'd8:    begin op_a = k0_r;                op_b = pct0_r;  end
      4'd9:    begin op_a = k0_r;                op_b = t1_r;    end
      4'd10:   begin op_a = k1_r;                op_b = pct0_r;  end
      4'd11:   begin op_a = k1_r;                op_b = t1_r;    end
      4'd12:   begin op_a = k0_r;                op_b = err_r;   end
      4'd13:   begin op_a = k1_r;                op_b = err_r;   end
      default: begin op_a = '0;                  op_b = '0;      end
    endcase
  end

  assign mul_en    = (state_r == S_MUL);
  assign div_start = (state_r == S_DIV) && !div_run_r;
  assign out_free  = !out_tvalid_r || out_tready;

  tak_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .q    (q)
  );

  tak_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_idx_r ? pct1_r : pct0_r),
    .den   (e_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= RST_TIME_STEP;
      qa_r <= RST_ANGLE_NOISE;
      qg_r <= RST_BIAS_NOISE;
      r_r  <= RST_MEASURE_NOISE;
      c_r  <= RST_OBSERVE_GAIN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TIME_STEP:     dt_r <= cfg_wdata[DT_W-1:0];
        CFG_ANGLE_NOISE:   qa_r <= cfg_wdata;
        CFG_BIAS_NOISE:    qg_r <= cfg_wdata;
        CFG_MEASURE_NOISE: r_r  <= cfg_wdata;
        CFG_OBSERVE_GAIN:  c_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= '0;
      div_idx_r    <= 1'b0;
      div_run_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      angle_r      <= '0;
      bias_r       <= '0;
      cov00_r      <= '0;
      cov01_r      <= '0;
      cov10_r      <= '0;
      cov11_r      <= '0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            meas_r  <= in_tdata[31:0];
            gyro_r  <= in_tdata[63:32];
            state_r <= S_PREP0;
          end
        end
        S_PREP0: begin
          u_r     <= sat_sub(gyro_r, bias_r);
          d0_r    <= sat_sub({1'b0, qa_r}, cov01_r);
          d1_r    <= sat_sub('0, cov11_r);
          step_r  <= '0;
          state_r <= S_PREP1;
        end
        S_PREP1: begin
          d0_r    <= sat_sub(d0_r, cov10_r);
          state_r <= S_MUL;
        end
        S_MUL: begin
          // The predicted angle is settled by the second step.
          if (step_r == 4'd1) begin
            err_r <= sat_sub(meas_r, angle_r);
          end
          state_r <= S_WB;
        end
        S_WB: begin
          case (step_r)
            4'd0:  angle_r <= sat_add(angle_r, q);
            4'd1:  cov00_r <= sat_add(cov00_r, q);
            4'd2: begin
              cov01_r <= sat_add(cov01_r, q);
              cov10_r <= sat_add(cov10_r, q);
            end
            4'd3:  cov11_r <= sat_add(cov11_r, q);
            4'd4:  pct0_r  <= q;
            4'd5:  pct1_r  <= q;
            4'd6:  e_r     <= sat_add({1'b0, r_r}, q);
            4'd7:  t1_r    <= q;
            4'd8:  cov00_r <= sat_sub(cov00_r, q);
            4'd9:  cov01_r <= sat_sub(cov01_r, q);
            4'd10: cov10_r <= sat_sub(cov10_r, q);
            4'd11: cov11_r <= sat_sub(cov11_r, q);
            4'd12: angle_r <= sat_add(angle_r, q);
            4'd13: bias_r  <= sat_add(bias_r, q);
            default: ;
          endcase
          if (step_r == LAST_PREDICT) begin
            div_idx_r <= 1'b0;
            div_run_r <= 1'b0;
            state_r   <= S_DIV;
          end else if (step_r == LAST_STEP) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL;
          end
          step_r <= step_r + 1'b1;
        end
        S_DIV: begin
          if (div_start) begin
            div_run_r <= 1'b1;
          end
          if (div_done) begin
            div_run_r <= 1'b0;
            if (!div_idx_r) begin
              k0_r      <= div_quo;
              div_idx_r <= 1'b1;
            end else begin
              k1_r    <= div_quo;
              state_r <= S_MUL;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_tdata_r <= {bias_r, sat_sub(gyro_r, bias_r), angle_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire
